@@ rtl/core/whl_pkg.sv @@
// Shared types, codes and helpers of the WebM header locator.
package whl_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKS_ID  = 2'd2;

  localparam logic [31:0] HEADER_ID_RST  = 32'h1A45DFA3;
  localparam logic [31:0] SEGMENT_ID_RST = 32'h18538067;
  localparam logic [31:0] TRACKS_ID_RST  = 32'h1654AE6B;

  // "webm" as four bytes
  localparam logic [31:0] DOCTYPE_WORD = 32'h7765626D;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_EBML   = 3'd1;
  localparam logic [2:0] ST_NOT_WEBM   = 3'd2;
  localparam logic [2:0] ST_NO_SEGMENT = 3'd3;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd4;
  localparam logic [2:0] ST_TRUNCATED  = 3'd5;

  typedef enum logic [2:0] {
    PH_HDR_ID    = 3'd0,
    PH_HDR_SIZE  = 3'd1,
    PH_HDR_BODY  = 3'd2,
    PH_SEG_ID    = 3'd3,
    PH_SEG_SIZE  = 3'd4,
    PH_CHILD_ID  = 3'd5,
    PH_CHILD_SZ  = 3'd6,
    PH_CHILD_SKP = 3'd7
  } whl_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } whl_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] segment_offset;
    logic [63:0] header_length;
  } whl_out_t;

  // Queue entry: the request plus the position of its leading one bit
  typedef struct packed {
    whl_in_t    req;
    logic [3:0] lead;
  } whl_entry_t;

  typedef struct packed {
    logic [31:0] header_id;
    logic [31:0] segment_id;
    logic [31:0] tracks_id;
  } whl_cfg_t;

  // Result before the length subtraction
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] segment_offset;
    logic [63:0] tracks_end;
    logic        have_tracks;
  } whl_raw_t;

  // 1 for bit 7 set, 8 for only bit 0 set, 0 for a zero byte
  function automatic logic [3:0] lead_one(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (n == 4'd0 && b[7-i]) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

@@ rtl/core/webm_header_locator_unit.sv @@
// Top level of the WebM header locator: configuration registers and the three stages.
//
// Feed the file one byte per request on in_valid/in_stall/in_data, from offset
// zero; mark the last byte with final_byte. Exactly one result follows each
// final byte on out_valid/out_stall/out_data: status, Segment offset and the
// length up to the end of the last Tracks child.
// Throughput is one byte per cycle: a small request queue feeds the parser,
// which consumes one byte each cycle from its head; only a final byte waits
// for the result slot to free.
// A final byte goes from the queue through the parser into the raw result slot;
// the output register is then loaded from that slot with the length subtraction.
// While out_stall is high the output holds, a second result waits in the raw
// slot, and the queue keeps taking bytes until QUEUE_DEPTH are waiting; then
// in_stall rises.
// Reset (rst_n low, synchronous) empties the queue and result stages, restores
// the three element IDs to their defaults and clears the parser; the parser
// also clears itself after every final byte. Write cfg_* only while idle.
module webm_header_locator_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [whl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [whl_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  whl_pkg::whl_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output whl_pkg::whl_out_t                     out_data
);

  whl_pkg::whl_cfg_t   cfg_r, cfg_nxt;
  logic                q_valid;
  whl_pkg::whl_entry_t q_entry;
  logic                q_pop;
  logic                res_valid;
  logic                res_ready;
  whl_pkg::whl_raw_t   res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        whl_pkg::CFG_HEADER_ID:  cfg_nxt.header_id  = cfg_wdata;
        whl_pkg::CFG_SEGMENT_ID: cfg_nxt.segment_id = cfg_wdata;
        whl_pkg::CFG_TRACKS_ID:  cfg_nxt.tracks_id  = cfg_wdata;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_id  <= whl_pkg::HEADER_ID_RST;
      cfg_r.segment_id <= whl_pkg::SEGMENT_ID_RST;
      cfg_r.tracks_id  <= whl_pkg::TRACKS_ID_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  whl_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  whl_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  whl_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/whl_front.sv @@
// Input side: takes byte requests, tags each with its length code, queues them.
module whl_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  whl_pkg::whl_in_t   in_data,
  output logic               q_valid,
  output whl_pkg::whl_entry_t q_entry,
  input  logic               q_pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  whl_pkg::whl_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign in_stall = (count_r == CNT_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].req  <= in_data;
      mem_r[wr_ptr_r].lead <= whl_pkg::lead_one(in_data.data_byte);
    end
  end

endmodule

@@ rtl/core/whl_parser.sv @@
// Element header parser: walks the EBML header, the Segment and its children.
module whl_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  whl_pkg::whl_cfg_t   cfg,
  input  logic                q_valid,
  input  whl_pkg::whl_entry_t q_entry,
  output logic                q_pop,
  input  logic                res_ready,
  output logic                res_valid,
  output whl_pkg::whl_raw_t   res
);

  whl_pkg::whl_phase_t phase_r, phase_nxt;
  logic [3:0]  hbc_r, hbc_nxt;
  logic [2:0]  idlen_r, idlen_nxt;
  logic [3:0]  szlen_r, szlen_nxt;
  logic [31:0] idacc_r, idacc_nxt;
  logic [55:0] szacc_r, szacc_nxt;
  logic [55:0] skip_r, skip_nxt;
  logic [63:0] pos1_r, pos1_nxt;
  logic [23:0] recent_r, recent_nxt;
  logic        seen_r, seen_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [63:0] off_r, off_nxt;
  logic [63:0] end_r, end_nxt;
  logic        have_r, have_nxt;

  logic [7:0]  b;
  logic [3:0]  lead;
  logic        fin;
  logic        take;
  logic        clear;
  logic        active;
  logic        first;
  logic        id_ph;
  logic        sz_ph;
  logic [2:0]  idlen_cur;
  logic [3:0]  szlen_cur;
  logic [3:0]  hbc_inc;
  logic        id_done;
  logic        sz_done;
  logic        id_bad;
  logic        sz_bad;
  logic [31:0] idacc_new;
  logic [7:0]  first_sz;
  logic [55:0] szacc_new;
  logic [31:0] win;
  logic        seen_new;
  logic        skip_last;
  logic [64:0] end_sum;
  logic [63:0] end_sat;
  logic [63:0] off_new;

  assign b     = q_entry.req.data_byte;
  assign lead  = q_entry.lead;
  assign fin   = q_entry.req.final_byte;
  // hold a final byte until the result slot is free
  assign take  = q_valid && (!fin || res_ready);
  assign clear = take && fin;
  assign q_pop = take;
  assign active = take && (err_r == whl_pkg::ST_OK);

  always_comb begin
    id_ph = 1'b0;
    sz_ph = 1'b0;
    case (phase_r) inside
      whl_pkg::PH_HDR_ID, whl_pkg::PH_SEG_ID, whl_pkg::PH_CHILD_ID:    id_ph = 1'b1;
      whl_pkg::PH_HDR_SIZE, whl_pkg::PH_SEG_SIZE, whl_pkg::PH_CHILD_SZ: sz_ph = 1'b1;
      default: ;
    endcase
  end

  assign first     = (hbc_r == 4'd0);
  assign idlen_cur = first ? ((lead <= 4'd4) ? lead[2:0] : 3'd0) : idlen_r;
  assign szlen_cur = first ? lead : szlen_r;
  assign hbc_inc   = hbc_r + 4'd1;
  assign id_done   = (hbc_inc >= {1'b0, idlen_cur});
  assign sz_done   = (hbc_inc >= szlen_cur);
  assign id_bad    = first && (idlen_cur == 3'd0);
  assign sz_bad    = first && (lead == 4'd0);
  assign idacc_new = first ? {24'd0, b} : {idacc_r[23:0], b};
  assign first_sz  = b & (8'hFF >> lead);
  assign szacc_new = first ? {48'd0, first_sz} : {szacc_r[47:0], b};
  assign win       = {recent_r, b};
  assign seen_new  = seen_r || (win == whl_pkg::DOCTYPE_WORD);
  assign skip_last = (skip_r == 56'd1);
  assign end_sum   = {1'b0, pos1_r} + {9'd0, szacc_new};
  assign end_sat   = end_sum[64] ? '1 : end_sum[63:0];
  assign off_new   = pos1_r - ({61'd0, idlen_r} + {60'd0, szlen_cur});

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (active) begin
      if (id_ph) begin
        if (!id_bad && id_done) begin
          phase_nxt = whl_pkg::whl_phase_t'(phase_r + 3'd1);
        end
      end else if (sz_ph) begin
        if (!sz_bad && sz_done) begin
          case (phase_r)
            whl_pkg::PH_HDR_SIZE: begin
              if (idacc_r == cfg.header_id && szacc_new != '0) begin
                phase_nxt = whl_pkg::PH_HDR_BODY;
              end
            end
            whl_pkg::PH_SEG_SIZE: begin
              if (idacc_r == cfg.segment_id) begin
                phase_nxt = whl_pkg::PH_CHILD_ID;
              end
            end
            default: begin
              phase_nxt = (szacc_new == '0) ? whl_pkg::PH_CHILD_ID : whl_pkg::PH_CHILD_SKP;
            end
          endcase
        end
      end else if (phase_r == whl_pkg::PH_HDR_BODY) begin
        if (skip_last && seen_new) begin
          phase_nxt = whl_pkg::PH_SEG_ID;
        end
      end else begin
        if (skip_last) begin
          phase_nxt = whl_pkg::PH_CHILD_ID;
        end
      end
    end
  end

  // datapath
  always_comb begin
    hbc_nxt    = hbc_r;
    idlen_nxt  = idlen_r;
    szlen_nxt  = szlen_r;
    idacc_nxt  = idacc_r;
    szacc_nxt  = szacc_r;
    skip_nxt   = skip_r;
    recent_nxt = recent_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    off_nxt    = off_r;
    end_nxt    = end_r;
    have_nxt   = have_r;
    pos1_nxt   = pos1_r;
    if (take) begin
      // saturate at the top
      pos1_nxt = (&pos1_r) ? pos1_r : pos1_r + 64'd1;
    end
    if (active) begin
      if (id_ph) begin
        if (id_bad) begin
          err_nxt = whl_pkg::ST_BAD_LENGTH;
        end else begin
          idlen_nxt = idlen_cur;
          idacc_nxt = idacc_new;
          hbc_nxt   = id_done ? 4'd0 : hbc_inc;
        end
      end else if (sz_ph) begin
        if (sz_bad) begin
          err_nxt = whl_pkg::ST_BAD_LENGTH;
        end else begin
          szlen_nxt = szlen_cur;
          szacc_nxt = szacc_new;
          hbc_nxt   = sz_done ? 4'd0 : hbc_inc;
          if (sz_done) begin
            case (phase_r)
              whl_pkg::PH_HDR_SIZE: begin
                if (idacc_r != cfg.header_id) begin
                  err_nxt = whl_pkg::ST_NOT_EBML;
                end else if (szacc_new == '0) begin
                  err_nxt = whl_pkg::ST_NOT_WEBM;
                end else begin
                  skip_nxt   = szacc_new;
                  recent_nxt = '0;
                  seen_nxt   = 1'b0;
                end
              end
              whl_pkg::PH_SEG_SIZE: begin
                if (idacc_r != cfg.segment_id) begin
                  err_nxt = whl_pkg::ST_NO_SEGMENT;
                end else begin
                  off_nxt = off_new;
                end
              end
              default: begin
                if (idacc_r == cfg.tracks_id) begin
                  end_nxt  = end_sat;
                  have_nxt = 1'b1;
                end
                skip_nxt = szacc_new;
              end
            endcase
          end
        end
      end else if (phase_r == whl_pkg::PH_HDR_BODY) begin
        recent_nxt = win[23:0];
        seen_nxt   = seen_new;
        skip_nxt   = skip_r - 56'd1;
        if (skip_last && !seen_new) begin
          err_nxt = whl_pkg::ST_NOT_WEBM;
        end
      end else begin
        skip_nxt = skip_r - 56'd1;
      end
    end
  end

  always_comb begin
    res_valid          = clear;
    res.segment_offset = off_nxt;
    res.tracks_end     = end_nxt;
    res.have_tracks    = have_nxt;
    if (err_nxt != whl_pkg::ST_OK) begin
      res.status = err_nxt;
    end else if (phase_nxt < whl_pkg::PH_CHILD_ID) begin
      res.status = whl_pkg::ST_TRUNCATED;
    end else begin
      res.status = whl_pkg::ST_OK;
    end
  end

  // a final byte returns every field to its reset value
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r  <= whl_pkg::PH_HDR_ID;
      hbc_r    <= '0;
      idlen_r  <= '0;
      szlen_r  <= '0;
      idacc_r  <= '0;
      szacc_r  <= '0;
      skip_r   <= '0;
      pos1_r   <= 64'd1;
      recent_r <= '0;
      seen_r   <= 1'b0;
      err_r    <= whl_pkg::ST_OK;
      off_r    <= '0;
      end_r    <= '0;
      have_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hbc_r    <= hbc_nxt;
      idlen_r  <= idlen_nxt;
      szlen_r  <= szlen_nxt;
      idacc_r  <= idacc_nxt;
      szacc_r  <= szacc_nxt;
      skip_r   <= skip_nxt;
      pos1_r   <= pos1_nxt;
      recent_r <= recent_nxt;
      seen_r   <= seen_nxt;
      err_r    <= err_nxt;
      off_r    <= off_nxt;
      end_r    <= end_nxt;
      have_r   <= have_nxt;
    end
  end

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pos1_r != 64'd0)
    else $error("byte position counter wrapped");

  a_err_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != whl_pkg::ST_OK) && !clear |=> err_r == $past(err_r))
    else $error("latched error changed before the final byte");

  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (phase_r == whl_pkg::PH_HDR_ID) && (err_r == whl_pkg::ST_OK) &&
              (pos1_r == 64'd1) && !have_r)
    else $error("state not cleared after final byte");

  a_tracks_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> phase_r >= whl_pkg::PH_CHILD_ID)
    else $error("tracks end recorded outside the segment");

endmodule

@@ rtl/core/whl_result.sv @@
// Result side: one slot for the raw result, then the output register.
module whl_result (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  whl_pkg::whl_raw_t res,
  output logic              out_valid,
  input  logic              out_stall,
  output whl_pkg::whl_out_t out_data
);

  logic              raw_valid_r, raw_valid_nxt;
  whl_pkg::whl_raw_t raw_r;
  logic              out_valid_r, out_valid_nxt;
  whl_pkg::whl_out_t out_r, out_nxt;
  logic              raw_move;

  assign raw_move  = raw_valid_r && (!out_valid_r || !out_stall);
  assign res_ready = !raw_valid_r || raw_move;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    raw_valid_nxt = raw_valid_r;
    if (res_valid && res_ready) begin
      raw_valid_nxt = 1'b1;
    end else if (raw_move) begin
      raw_valid_nxt = 1'b0;
    end
    out_valid_nxt = raw_move || (out_valid_r && out_stall);
    out_nxt.status         = raw_r.status;
    out_nxt.segment_offset = raw_r.segment_offset;
    out_nxt.header_length  = raw_r.have_tracks ?
                             raw_r.tracks_end - raw_r.segment_offset : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      raw_valid_r <= raw_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      raw_r <= res;
    end
    if (raw_move) begin
      out_r <= out_nxt;
    end
  end

endmodule

@@ dv/webm_header_locator_unit_tb.sv @@
// Self-checking testbench of the WebM header locator: directed table, then random files.
module webm_header_locator_unit_tb;

  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 80;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    logic [2:0] st;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [whl_pkg::CFG_IDX_W-1:0] cfg_index = whl_pkg::CFG_HEADER_ID;
  logic [whl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  whl_pkg::whl_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  whl_pkg::whl_out_t out_data;

  webm_header_locator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed requests: typed rows carry their status, the rest go through the parser model
  row_t directed_rows [21] = '{
    '{8'h00, 1'b1, 1'b1, whl_pkg::ST_BAD_LENGTH},   // zero first ID byte
    '{8'hFF, 1'b1, 1'b1, whl_pkg::ST_TRUNCATED},    // one-byte ID, file ends
    '{8'h80, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'h81, 1'b1, 1'b1, whl_pkg::ST_NOT_EBML},
    '{8'h80, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'h00, 1'b1, 1'b1, whl_pkg::ST_BAD_LENGTH},   // zero size byte beats the ID compare
    '{8'h1A, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'h45, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'hDF, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'hA3, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'h80, 1'b1, 1'b1, whl_pkg::ST_NOT_WEBM},     // empty EBML header
    '{8'h1A, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'h45, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'hDF, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'hA3, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'h84, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'h77, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'h65, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'h62, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'h6D, 1'b0, 1'b0, whl_pkg::ST_OK},
    '{8'h18, 1'b1, 1'b0, whl_pkg::ST_OK}            // cut inside the Segment ID
  };

  // Parser model state
  logic [31:0] hdr_id_cfg, seg_id_cfg, trk_id_cfg;
  whl_pkg::whl_phase_t ph;
  logic [3:0]  field_cnt;
  logic [2:0]  id_bytes;
  logic [3:0]  sz_bytes;
  logic [31:0] id_val;
  logic [63:0] sz_val, skip_left, file_pos, seg_off, trk_len;
  logic [23:0] last3;
  logic        doc_ok;
  logic [2:0]  err_st;

  whl_pkg::whl_out_t verdict_q[$];
  logic [7:0] file_q[$];

  int errors = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int results_checked = 0;
  int status_seen [6] = '{default: 0};
  int burst_left = 0;
  int quiet_cycles = 0;

  logic hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_span = 0;

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic void clear_parse();
    ph = whl_pkg::PH_HDR_ID;
    field_cnt = '0;
    id_bytes = '0;
    sz_bytes = '0;
    id_val = '0;
    sz_val = '0;
    skip_left = '0;
    file_pos = '0;
    last3 = '0;
    doc_ok = 1'b0;
    err_st = whl_pkg::ST_OK;
    seg_off = '0;
    trk_len = '0;
  endfunction

  function automatic void close_size(input logic [63:0] at);
    logic [63:0] tail;
    field_cnt = '0;
    case (ph)
      whl_pkg::PH_HDR_SIZE: begin
        if (id_val != hdr_id_cfg) err_st = whl_pkg::ST_NOT_EBML;
        else if (sz_val == 0) err_st = whl_pkg::ST_NOT_WEBM;
        else begin
          skip_left = sz_val;
          last3 = '0;
          doc_ok = 1'b0;
          ph = whl_pkg::PH_HDR_BODY;
        end
      end
      whl_pkg::PH_SEG_SIZE: begin
        if (id_val != seg_id_cfg) err_st = whl_pkg::ST_NO_SEGMENT;
        else begin
          seg_off = add_sat(at, 64'd1) - 64'(id_bytes) - 64'(sz_bytes);
          ph = whl_pkg::PH_CHILD_ID;
        end
      end
      default: begin
        tail = add_sat(add_sat(at, 64'd1), sz_val);
        if (id_val == trk_id_cfg) trk_len = tail - seg_off;
        if (sz_val == 0) ph = whl_pkg::PH_CHILD_ID;
        else begin
          skip_left = sz_val;
          ph = whl_pkg::PH_CHILD_SKP;
        end
      end
    endcase
  endfunction

  function automatic void consume(input logic [7:0] b, input logic [63:0] at);
    logic [31:0] win;
    logic [3:0] n;
    case (ph)
      whl_pkg::PH_HDR_ID, whl_pkg::PH_SEG_ID, whl_pkg::PH_CHILD_ID: begin
        if (field_cnt == 0) begin
          id_bytes = b[7] ? 3'd1 : b[6] ? 3'd2 : b[5] ? 3'd3 : b[4] ? 3'd4 : 3'd0;
          if (id_bytes == 0) begin
            err_st = whl_pkg::ST_BAD_LENGTH;
            return;
          end
          id_val = {24'd0, b};
        end else begin
          id_val = {id_val[23:0], b};
        end
        field_cnt = field_cnt + 4'd1;
        if (field_cnt >= {1'b0, id_bytes}) begin
          field_cnt = '0;
          ph = whl_pkg::whl_phase_t'(ph + 3'd1);
        end
      end
      whl_pkg::PH_HDR_SIZE, whl_pkg::PH_SEG_SIZE, whl_pkg::PH_CHILD_SZ: begin
        if (field_cnt == 0) begin
          n = '0;
          // the highest set bit is seen last and wins
          for (int k = 0; k < 8; k++) if (b[k]) n = 4'(8 - k);
          if (n == 0) begin
            err_st = whl_pkg::ST_BAD_LENGTH;
            return;
          end
          sz_bytes = n;
          sz_val = 64'(b & (8'hFF >> n));
        end else begin
          sz_val = {sz_val[55:0], b};
        end
        field_cnt = field_cnt + 4'd1;
        if (field_cnt >= sz_bytes) close_size(at);
      end
      whl_pkg::PH_HDR_BODY: begin
        win = {last3, b};
        if (win == whl_pkg::DOCTYPE_WORD) doc_ok = 1'b1;
        last3 = win[23:0];
        skip_left = skip_left - 64'd1;
        if (skip_left == 0) begin
          if (!doc_ok) err_st = whl_pkg::ST_NOT_WEBM;
          else ph = whl_pkg::PH_SEG_ID;
        end
      end
      default: begin
        skip_left = skip_left - 64'd1;
        if (skip_left == 0) ph = whl_pkg::PH_CHILD_ID;
      end
    endcase
  endfunction

  function automatic bit parse_byte(input whl_pkg::whl_in_t r, output whl_pkg::whl_out_t v);
    if (err_st == whl_pkg::ST_OK) consume(r.data_byte, file_pos);
    file_pos = add_sat(file_pos, 64'd1);
    v = '0;
    if (!r.final_byte) return 1'b0;
    if (err_st != whl_pkg::ST_OK) v.status = err_st;
    else if (ph < whl_pkg::PH_CHILD_ID) v.status = whl_pkg::ST_TRUNCATED;
    else v.status = whl_pkg::ST_OK;
    v.segment_offset = seg_off;
    v.header_length = trk_len;
    clear_parse();
    return 1'b1;
  endfunction

  function automatic void push_id(input logic [31:0] v);
    int k;
    if (v[31:24] != 0) k = 4;
    else if (v[23:16] != 0) k = 3;
    else if (v[15:8] != 0) k = 2;
    else k = 1;
    for (int j = k - 1; j >= 0; j--) file_q.push_back(v[8*j +: 8]);
  endfunction

  function automatic void push_size(input logic [63:0] v, input int n);
    logic [63:0] w;
    w = v | (64'd1 << (7 * n));
    for (int k = n - 1; k >= 0; k--) file_q.push_back(w[8*k +: 8]);
  endfunction

  // Mostly well-formed files with random content; some cut short, some damaged, some noise
  task automatic build_file();
    int kind, plen, spot, kids, idw, sz, n;
    logic [7:0] lead;
    file_q.delete();
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
      return;
    end
    push_id(hdr_id_cfg);
    plen = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(4, 10);
    push_size(64'(plen), $urandom_range(1, 8));
    spot = -1;
    if (plen >= 4 && $urandom_range(0, 4) != 0) spot = $urandom_range(0, plen - 4);
    for (int j = 0; j < plen; j++) begin
      if (spot >= 0 && j >= spot && j < spot + 4)
        file_q.push_back(whl_pkg::DOCTYPE_WORD[8*(3-j+spot) +: 8]);
      else file_q.push_back(8'($urandom));
    end
    push_id(seg_id_cfg);
    n = $urandom_range(1, 8);
    push_size({$urandom, $urandom} & ((64'd1 << (7 * n)) - 64'd1), n);
    kids = $urandom_range(0, 4);
    for (int c = 0; c < kids; c++) begin
      if ($urandom_range(0, 2) == 0) push_id(trk_id_cfg);
      else begin
        idw = $urandom_range(1, 4);
        lead = 8'h80 >> (idw - 1);
        file_q.push_back(lead | (8'($urandom) & (lead - 8'd1)));
        repeat (idw - 1) file_q.push_back(8'($urandom));
      end
      if (c == kids - 1 && $urandom_range(0, 7) == 0) begin
        // huge last child: the file ends while it is being skipped
        push_size({$urandom, $urandom} & 64'h00FF_FFFF_FFFF_FFFF, 8);
        repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom));
      end else begin
        sz = $urandom_range(0, 5);
        push_size(64'(sz), $urandom_range(1, 8));
        repeat (sz) file_q.push_back(8'($urandom));
      end
    end
    if (kind < 5) begin
      spot = $urandom_range(1, file_q.size());
      while (file_q.size() > spot) file_q.delete(file_q.size() - 1);
    end else if (kind < 8) begin
      spot = $urandom_range(0, file_q.size() - 1);
      file_q[spot] = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom);
    end
  endtask

  // Offer one request in bursts with gaps; hold it until taken, then predict
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input logic [2:0] st);
    whl_pkg::whl_in_t req;
    whl_pkg::whl_out_t v;
    bit got;
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap = $urandom_range(1, 6);
      while (gap > 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
        gap--;
      end
    end
    burst_left--;
    req.data_byte = b;
    req.final_byte = fin;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    got = parse_byte(req, v);
    if (typed && fin)
      verdict_q.push_back('{status: st, segment_offset: '0, header_length: '0});
    else if (got) verdict_q.push_back(v);
  endtask

  task automatic run_files(input int min_bytes, input int min_files);
    int nb, nf;
    nb = 0;
    nf = 0;
    while (nb < min_bytes || nf < min_files) begin
      build_file();
      foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1, 1'b0, whl_pkg::ST_OK);
      nb += file_q.size();
      nf++;
      files_sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ids(input logic [31:0] h, input logic [31:0] s, input logic [31:0] t);
    logic [whl_pkg::CFG_IDX_W-1:0] idx [3];
    logic [31:0] val [3];
    idx = '{whl_pkg::CFG_HEADER_ID, whl_pkg::CFG_SEGMENT_ID, whl_pkg::CFG_TRACKS_ID};
    val = '{h, s, t};
    for (int k = 0; k < 3; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    hdr_id_cfg = h;
    seg_id_cfg = s;
    trk_id_cfg = t;
  endtask

  // Receiver: changing stall patterns, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_span == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_span = $urandom_range(10, 80);
      end
      rx_span--;
      case (rx_mode)
        RX_OPEN: out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    whl_pkg::whl_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (out_data.status <= whl_pkg::ST_TRUNCATED) status_seen[out_data.status]++;
      if (verdict_q.size() == 0) begin
        $display("%0t: result with none pending: expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        results_checked++;
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
          errors++;
        end
        if (out_data.segment_offset !== want.segment_offset) begin
          $display("%0t: segment_offset expected %0d actual %0d", $time,
                   want.segment_offset, out_data.segment_offset);
          errors++;
        end
        if (out_data.header_length !== want.header_length) begin
          $display("%0t: header_length expected %0d actual %0d", $time,
                   want.header_length, out_data.header_length);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results pending", $time,
               QUIET_LIMIT, verdict_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    hdr_id_cfg = whl_pkg::HEADER_ID_RST;
    seg_id_cfg = whl_pkg::SEGMENT_ID_RST;
    trk_id_cfg = whl_pkg::TRACKS_ID_RST;
    clear_parse();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].typed,
                directed_rows[i].st);
    run_files(80, 2);
    drain();
    set_ids(32'h0000_0081, 32'h0000_4286, 32'h002A_BCDE);
    run_files(80, 2);
    drain();
    set_ids(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    run_files(0, 1);
    drain();
    set_ids(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_files(0, 1);
    drain();
    set_ids(whl_pkg::HEADER_ID_RST, whl_pkg::SEGMENT_ID_RST, whl_pkg::TRACKS_ID_RST);
    // stall the output long enough for one-byte files to back up into the input
    hold_req <= 1'b1;
    repeat (16) send_byte(8'($urandom), 1'b1, 1'b0, whl_pkg::ST_OK);
    run_files(80, 2);
    drain();
    $display("Run covered %0d input bytes, %0d random files and %0d checked results",
             bytes_sent, files_sent, results_checked);
    $display("over five ID settings; status mix: ok %0d, not EBML %0d, not webm %0d,",
             status_seen[0], status_seen[1], status_seen[2]);
    $display("no Segment %0d, bad length %0d, truncated %0d",
             status_seen[3], status_seen[4], status_seen[5]);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
